// ===== src/apmb_pkg.sv =====
// apmb_pkg: shared widths, constants and controller/datapath interface types
// for the audio peak mipmap builder. No dependencies.
`default_nettype none
package apmb_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 18;

  // derived widths
  localparam int CHAN_W   = $clog2(MAX_CHANNELS + 1);
  localparam int SUM_W    = SAMPLE_BITS + $clog2(MAX_CHANNELS);
  localparam int DCNT_W   = $clog2(SUM_W + 1);
  localparam int CLAMP_W  = 17;
  localparam int PEAK_W   = 16;
  localparam int CMP_W    = (SUM_W + 1 > CLAMP_W + 1) ? SUM_W + 1 : CLAMP_W + 1;

  // register field widths
  localparam int CCOUNT_W = 4;
  localparam int FRAME_W  = 16;
  localparam int GROUP_W  = 10;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 4;

  // full scale of the clamp, q2.15 one
  localparam int FULL_SCALE = 32768;

  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [1:0] REG_CHUNK_FRAMES  = 2'd1;
  localparam logic [1:0] REG_MIPMAP_SCALE  = 2'd2;

  localparam logic [CCOUNT_W-1:0] CHANNEL_COUNT_RST = 4'd2;
  localparam logic [FRAME_W-1:0]  CHUNK_FRAMES_RST  = 16'd512;
  localparam logic [GROUP_W-1:0]  MIPMAP_SCALE_RST  = 10'd20;

  localparam logic LEVEL_CHUNK  = 1'b0;
  localparam logic LEVEL_MIPMAP = 1'b1;

  typedef struct packed {
    logic capture;      // take the input item
    logic frame_close;  // fold divided mono value into chunk min/max
    logic load_chunk;   // emit chunk pair, merge into group
    logic load_group;   // emit group pair, clear group
    logic flush;        // end of stream: emit tail group if any, clear all
  } apmb_cmd_t;

  typedef struct packed {
    logic frame_closes;
    logic div_done;
    logic emit_chunk;
    logic group_closes;
    logic eos;
    logic has_tail;
    logic out_free;
  } apmb_stat_t;

endpackage
`default_nettype wire

// ===== src/apmb_div.sv =====
// apmb_div: serial restoring divider, one quotient bit per cycle.
// Unsigned dividend by the channel count. Depends on apmb_pkg.
`default_nettype none
module apmb_div
  import apmb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  dividend_i,
  input  wire logic [CHAN_W-1:0] divisor_i,
  output logic      [SUM_W-1:0]  quotient_o,
  output logic                   done_o
);

  logic [SUM_W-1:0]  work_q, work_d;
  logic [CHAN_W-1:0] rem_q, rem_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CHAN_W:0]   trial;
  logic [CHAN_W:0]   diff;
  logic              ge;

  assign trial = {rem_q, work_q[SUM_W-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    work_d = work_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      work_d = dividend_i;
      rem_d  = '0;
      cnt_d  = DCNT_W'(SUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0];
      work_d = {work_q[SUM_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
  end

  assign quotient_o = work_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

// ===== src/apmb_dp.sv =====
// apmb_dp: datapath of the peak builder: frame sum, chunk and group peak
// registers, output register. Depends on apmb_pkg and apmb_div.
`default_nettype none
module apmb_dp
  import apmb_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire apmb_cmd_t                     cmd_i,
  output apmb_stat_t                         stat_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          end_of_stream_i,
  input  wire logic [CHAN_W-1:0]             chans_i,
  input  wire logic [FRAME_W-1:0]            chunk_frames_i,
  input  wire logic [GROUP_W-1:0]            mipmap_scale_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               level_o,
  output logic signed [PEAK_W-1:0]           peak_min_o,
  output logic signed [PEAK_W-1:0]           peak_max_o,
  output logic                               last_of_run_o
);

  localparam logic signed [CMP_W-1:0]   CMP_HI   = CMP_W'(FULL_SCALE);
  localparam logic signed [CMP_W-1:0]   CMP_LO   = CMP_W'(-FULL_SCALE);
  localparam logic signed [CLAMP_W-1:0] CLAMP_HI = CLAMP_W'(FULL_SCALE);
  localparam logic signed [CLAMP_W-1:0] CLAMP_LO = CLAMP_W'(-FULL_SCALE);

  // v * 32767 / 32768 toward zero is v - sign(v) for |v| <= 32768
  function automatic logic signed [PEAK_W-1:0] to_peak(input logic signed [CLAMP_W-1:0] v);
    logic signed [CLAMP_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v[CLAMP_W-1]) begin
      r = v + CLAMP_W'(1);
    end else begin
      r = v - CLAMP_W'(1);
    end
    return r[PEAK_W-1:0];
  endfunction

  logic signed [SUM_W-1:0]   frame_sum_q;
  logic [CHAN_W-1:0]         chan_idx_q;
  logic [FRAME_W-1:0]        frame_idx_q;
  logic signed [CLAMP_W-1:0] chunk_min_q, chunk_max_q;
  logic [GROUP_W-1:0]        group_idx_q;
  logic signed [PEAK_W-1:0]  group_min_q, group_max_q;
  logic                      has_tail_q;
  logic                      eos_q;
  logic                      closed_q;
  logic                      neg_q;

  logic                      out_valid_q;
  logic                      level_q, last_q;
  logic signed [PEAK_W-1:0]  pmin_q, pmax_q;

  logic signed [SUM_W-1:0]   sample_ext;
  logic signed [SUM_W-1:0]   sum_next;
  logic [SUM_W-1:0]          sum_mag;
  logic [CHAN_W-1:0]         idx_next;
  logic [SUM_W-1:0]          quo;
  logic                      div_done;
  logic signed [CMP_W-1:0]   quo_ext, mono;
  logic signed [CLAMP_W-1:0] mono_cl;
  logic signed [PEAK_W-1:0]  chunk_pmin, chunk_pmax;
  logic [GROUP_W:0]          group_next;
  logic                      out_free;

  assign sample_ext = {{(SUM_W-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign sum_next   = frame_sum_q + sample_ext;
  assign sum_mag    = sum_next[SUM_W-1] ? $unsigned(-sum_next) : $unsigned(sum_next);
  assign idx_next   = chan_idx_q + CHAN_W'(1);

  apmb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.capture && stat_o.frame_closes),
    .dividend_i (sum_mag),
    .divisor_i  (chans_i),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // restore sign, then clamp to [-1, 1]
  assign quo_ext = $signed({{(CMP_W-SUM_W){1'b0}}, quo});
  assign mono    = neg_q ? -quo_ext : quo_ext;

  always_comb begin
    if (mono > CMP_HI) begin
      mono_cl = CLAMP_HI;
    end else if (mono < CMP_LO) begin
      mono_cl = CLAMP_LO;
    end else begin
      mono_cl = mono[CLAMP_W-1:0];
    end
  end

  assign chunk_pmin = to_peak(chunk_min_q);
  assign chunk_pmax = to_peak(chunk_max_q);
  assign group_next = {1'b0, group_idx_q} + (GROUP_W+1)'(1);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    stat_o.frame_closes = idx_next >= chans_i;
    stat_o.div_done     = div_done;
    stat_o.emit_chunk   = (closed_q && (frame_idx_q >= chunk_frames_i))
                          || (eos_q && (frame_idx_q != '0));
    stat_o.group_closes = group_next >= {1'b0, mipmap_scale_i};
    stat_o.eos          = eos_q;
    stat_o.has_tail     = has_tail_q;
    stat_o.out_free     = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_sum_q <= '0;
      chan_idx_q  <= '0;
      frame_idx_q <= '0;
      chunk_min_q <= '0;
      chunk_max_q <= '0;
      group_idx_q <= '0;
      group_min_q <= '0;
      group_max_q <= '0;
      has_tail_q  <= 1'b0;
      eos_q       <= 1'b0;
      closed_q    <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // a new result may replace one that leaves at the same edge
      if (cmd_i.load_chunk || cmd_i.load_group || (cmd_i.flush && has_tail_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.capture) begin
        frame_sum_q <= sum_next;
        chan_idx_q  <= idx_next;
        eos_q       <= end_of_stream_i;
        closed_q    <= stat_o.frame_closes;
        neg_q       <= sum_next[SUM_W-1];
      end
      if (cmd_i.frame_close) begin
        if (mono_cl < chunk_min_q) begin
          chunk_min_q <= mono_cl;
        end
        if (mono_cl > chunk_max_q) begin
          chunk_max_q <= mono_cl;
        end
        frame_sum_q <= '0;
        chan_idx_q  <= '0;
        frame_idx_q <= frame_idx_q + FRAME_W'(1);
      end
      if (cmd_i.load_chunk) begin
        chunk_min_q <= '0;
        chunk_max_q <= '0;
        frame_idx_q <= '0;
        if (chunk_pmin < group_min_q) begin
          group_min_q <= chunk_pmin;
        end
        if (chunk_pmax > group_max_q) begin
          group_max_q <= chunk_pmax;
        end
        has_tail_q  <= 1'b1;
        group_idx_q <= group_next[GROUP_W-1:0];
      end
      if (cmd_i.load_group) begin
        group_min_q <= '0;
        group_max_q <= '0;
        group_idx_q <= '0;
        has_tail_q  <= 1'b0;
      end
      if (cmd_i.flush) begin
        frame_sum_q <= '0;
        chan_idx_q  <= '0;
        frame_idx_q <= '0;
        chunk_min_q <= '0;
        chunk_max_q <= '0;
        group_idx_q <= '0;
        group_min_q <= '0;
        group_max_q <= '0;
        has_tail_q  <= 1'b0;
        eos_q       <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_chunk) begin
      level_q <= LEVEL_CHUNK;
      pmin_q  <= chunk_pmin;
      pmax_q  <= chunk_pmax;
      last_q  <= !(stat_o.group_closes || eos_q);
    end else if (cmd_i.load_group || (cmd_i.flush && has_tail_q)) begin
      level_q <= LEVEL_MIPMAP;
      pmin_q  <= group_min_q;
      pmax_q  <= group_max_q;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign level_o       = level_q;
  assign peak_min_o    = pmin_q;
  assign peak_max_o    = pmax_q;
  assign last_of_run_o = last_q;

endmodule
`default_nettype wire

// ===== src/apmb_ctrl.sv =====
// apmb_ctrl: sequencing state machine for the peak builder; drives the
// datapath by command struct. Depends on apmb_pkg.
`default_nettype none
module apmb_ctrl
  import apmb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire apmb_stat_t stat_i,
  output apmb_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_TAIL  = 7'b0000100,
    S_CHUNK = 7'b0001000,
    S_GROUP = 7'b0010000,
    S_EOS   = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = stat_i.frame_closes ? S_DIV : S_TAIL;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.frame_close = 1'b1;
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        if (stat_i.emit_chunk) begin
          state_d = S_CHUNK;
        end else if (stat_i.eos) begin
          state_d = S_EOS;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CHUNK: begin
        if (stat_i.out_free) begin
          cmd_o.load_chunk = 1'b1;
          if (stat_i.group_closes) begin
            state_d = S_GROUP;
          end else if (stat_i.eos) begin
            state_d = S_EOS;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_GROUP: begin
        if (stat_i.out_free) begin
          cmd_o.load_group = 1'b1;
          state_d = stat_i.eos ? S_EOS : S_IDLE;
        end
      end
      S_EOS: begin
        // a tail group needs the output register
        if (!stat_i.has_tail || stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SPARE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/audio_peak_mipmap_builder.sv =====
// audio_peak_mipmap_builder: top level with the configuration registers.
// Depends on apmb_pkg, apmb_ctrl, apmb_dp (and apmb_div below it).
//
// Builds waveform peaks from interleaved signed q2.15 samples: each frame is
// averaged to mono (truncating division by the channel count), each chunk of
// chunk_frames mono values gives a level 0 min/max pair scaled to 16 bits, and
// every mipmap_scale chunk pairs merge into a level 1 pair; end_of_stream
// flushes a partial chunk and a partial group and returns all state to reset.
// One item is handled at a time. A sample that closes a frame waits for the
// serial divider (one quotient bit per cycle, 21 bits), then passes the tail
// check, a state for each result it causes and one more at end of stream;
// any other sample skips the divider. A result that waits for the receiver
// adds its wait. Results leave through an output register, so the next item
// is taken while the last result of the previous one waits.
`default_nettype none
module audio_peak_mipmap_builder
  import apmb_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          end_of_stream_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               level_o,
  output logic signed [PEAK_W-1:0]           peak_min_o,
  output logic signed [PEAK_W-1:0]           peak_max_o,
  output logic                               last_of_run_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [PADDR_W-1:0]            paddr,
  input  wire logic [PDATA_W-1:0]            pwdata,
  output logic [PDATA_W-1:0]                 prdata,
  output logic                               pready
);

  logic [CCOUNT_W-1:0] channel_count_q;
  logic [FRAME_W-1:0]  chunk_frames_q;
  logic [GROUP_W-1:0]  mipmap_scale_q;
  logic                wr_en;
  logic [CHAN_W-1:0]   chans;
  logic [FRAME_W-1:0]  cf_eff;
  logic [GROUP_W-1:0]  ms_eff;
  apmb_cmd_t           cmd;
  apmb_stat_t          stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= CHANNEL_COUNT_RST;
      chunk_frames_q  <= CHUNK_FRAMES_RST;
      mipmap_scale_q  <= MIPMAP_SCALE_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_CHANNEL_COUNT: channel_count_q <= pwdata[CCOUNT_W-1:0];
        REG_CHUNK_FRAMES:  chunk_frames_q  <= pwdata[FRAME_W-1:0];
        REG_MIPMAP_SCALE:  mipmap_scale_q  <= pwdata[GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CHANNEL_COUNT: prdata = PDATA_W'(channel_count_q);
      REG_CHUNK_FRAMES:  prdata = PDATA_W'(chunk_frames_q);
      REG_MIPMAP_SCALE:  prdata = PDATA_W'(mipmap_scale_q);
      default:           prdata = '0;
    endcase
  end

  // zero acts as one, channel count saturates at the supported maximum
  always_comb begin
    if (channel_count_q == '0) begin
      chans = CHAN_W'(1);
    end else if (32'(channel_count_q) > 32'(MAX_CHANNELS)) begin
      chans = CHAN_W'(MAX_CHANNELS);
    end else begin
      chans = CHAN_W'(channel_count_q);
    end
  end

  assign cf_eff = (chunk_frames_q == '0) ? FRAME_W'(1) : chunk_frames_q;
  assign ms_eff = (mipmap_scale_q == '0) ? GROUP_W'(1) : mipmap_scale_q;

  apmb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  apmb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .sample_i        (sample_i),
    .end_of_stream_i (end_of_stream_i),
    .chans_i         (chans),
    .chunk_frames_i  (cf_eff),
    .mipmap_scale_i  (ms_eff),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .level_o         (level_o),
    .peak_min_o      (peak_min_o),
    .peak_max_o      (peak_max_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
`default_nettype wire

// ===== dv/tb_audio_peak_mipmap_builder.sv =====
// tb_audio_peak_mipmap_builder: self-checking testbench for the audio peak mipmap builder.
// Depends on apmb_pkg and audio_peak_mipmap_builder. A peak tracker class predicts
// the chunk and mipmap pairs, and random handshake stalls drive the block.
`timescale 1ns / 1ps
module tb_audio_peak_mipmap_builder;
  import apmb_pkg::*;

  typedef struct packed {
    logic                     level;
    logic signed [PEAK_W-1:0] pmin;
    logic signed [PEAK_W-1:0] pmax;
    logic                     last;
  } peak_pair_t;

  class peak_tracker;
    peak_pair_t  pending_peaks[$];
    int          errors;
    int unsigned chan_cfg, frames_cfg, scale_cfg;
    longint      frame_sum, chunk_min, chunk_max;
    int          chan_idx, frame_idx, group_idx, group_min, group_max;
    bit          has_tail;

    function new();
      errors     = 0;
      chan_cfg   = CHANNEL_COUNT_RST;
      frames_cfg = CHUNK_FRAMES_RST;
      scale_cfg  = MIPMAP_SCALE_RST;
      clear_state();
    endfunction

    function void clear_state();
      frame_sum = 0;
      chunk_min = 0;
      chunk_max = 0;
      chan_idx  = 0;
      frame_idx = 0;
      group_idx = 0;
      group_min = 0;
      group_max = 0;
      has_tail  = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_CHANNEL_COUNT: chan_cfg = value & 32'hF;
        REG_CHUNK_FRAMES: frames_cfg = value & 32'hFFFF;
        REG_MIPMAP_SCALE: scale_cfg = value & 32'h3FF;
        default: ;
      endcase
    endfunction

    // clamp to q2.15 [-1,1], then scale by 32767/32768 toward zero
    function int scale_peak(longint v);
      if (v < -FULL_SCALE) v = -FULL_SCALE;
      else if (v > FULL_SCALE) v = FULL_SCALE;
      return int'((v * 32767) / FULL_SCALE);
    endfunction

    function void take_sample(logic signed [SAMPLE_BITS-1:0] s, bit eos);
      int         chans, cf, ms, mn, mx;
      longint     mono;
      bit         close_chunk;
      peak_pair_t run[$];
      chans = (chan_cfg == 0) ? 1 : (chan_cfg > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_cfg);
      cf = (frames_cfg == 0) ? 1 : int'(frames_cfg);
      ms = (scale_cfg == 0) ? 1 : int'(scale_cfg);
      close_chunk = 0;
      frame_sum += s;
      chan_idx++;
      if (chan_idx >= chans) begin
        mono = frame_sum / chans;
        if (mono < chunk_min) chunk_min = mono;
        if (mono > chunk_max) chunk_max = mono;
        frame_sum = 0;
        chan_idx  = 0;
        frame_idx++;
        if (frame_idx >= cf) close_chunk = 1;
      end
      // a partial frame is dropped, but a partial chunk is flushed
      if (eos && frame_idx > 0) close_chunk = 1;
      if (close_chunk) begin
        mn = scale_peak(chunk_min);
        mx = scale_peak(chunk_max);
        run.push_back('{LEVEL_CHUNK, PEAK_W'(mn), PEAK_W'(mx), 1'b0});
        chunk_min = 0;
        chunk_max = 0;
        frame_idx = 0;
        if (mn < group_min) group_min = mn;
        if (mx > group_max) group_max = mx;
        has_tail = 1;
        group_idx++;
        if (group_idx >= ms) begin
          run.push_back('{LEVEL_MIPMAP, PEAK_W'(group_min), PEAK_W'(group_max), 1'b0});
          group_min = 0;
          group_max = 0;
          group_idx = 0;
          has_tail  = 0;
        end
      end
      if (eos) begin
        if (has_tail) run.push_back('{LEVEL_MIPMAP, PEAK_W'(group_min), PEAK_W'(group_max), 1'b0});
        clear_state();
      end
      if (run.size() > 0) run[run.size()-1].last = 1'b1;
      foreach (run[i]) pending_peaks.push_back(run[i]);
    endfunction

    function void match_peak(peak_pair_t got);
      peak_pair_t want;
      if (pending_peaks.size() == 0) begin
        $error("unexpected result: level %0d min %0d max %0d last %0d",
               got.level, got.pmin, got.pmax, got.last);
        errors++;
        return;
      end
      want = pending_peaks.pop_front();
      if (got.level !== want.level) begin
        $error("level: expected %0d, got %0d", want.level, got.level);
        errors++;
      end
      if (got.pmin !== want.pmin) begin
        $error("peak_min: expected %0d, got %0d", want.pmin, got.pmin);
        errors++;
      end
      if (got.pmax !== want.pmax) begin
        $error("peak_max: expected %0d, got %0d", want.pmax, got.pmax);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic                          end_of_stream_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          level_o;
  logic signed [PEAK_W-1:0]      peak_min_o;
  logic signed [PEAK_W-1:0]      peak_max_o;
  logic                          last_of_run_o;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [PADDR_W-1:0]            paddr;
  logic [PDATA_W-1:0]            pwdata;
  logic [PDATA_W-1:0]            prdata;
  logic                          pready;

  peak_tracker tracker;
  bit          tx_calm;
  bit          rx_calm;
  bit          hold_req;

  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;

  audio_peak_mipmap_builder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .end_of_stream_i(end_of_stream_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .level_o        (level_o),
    .peak_min_o     (peak_min_o),
    .peak_max_o     (peak_max_o),
    .last_of_run_o  (last_of_run_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // write one register, then read it back
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] readback;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.set_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT: value = value & 32'hF;
      REG_CHUNK_FRAMES: value = value & 32'hFFFF;
      default: value = value & 32'h3FF;
    endcase
    if (readback !== value) begin
      $error("prdata: expected %0d, got %0d", value, readback);
      tracker.errors++;
    end
  endtask

  task automatic configure(input int unsigned cc, input int unsigned cf, input int unsigned ms);
    write_reg(REG_CHANNEL_COUNT, cc);
    write_reg(REG_CHUNK_FRAMES, cf);
    write_reg(REG_MIPMAP_SCALE, ms);
  endtask

  // valid stays high into the next item when there is no gap
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit eos);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sample_i        <= s;
    end_of_stream_i <= eos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.take_sample(s, eos);
    @(negedge clk_i);
  endtask

  // called right after a send, on a falling edge with no other drive pending
  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_peaks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    logic signed [SAMPLE_BITS-1:0] s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = SAMPLE_BITS'($urandom);
      4, 5: s = SAMPLE_BITS'($signed($urandom_range(0, 400)) - 200);
      6: s = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      7: s = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      8: begin
        s = SAMPLE_BITS'($urandom_range(32760, 32776));
        if ($urandom_range(0, 1)) s = -s;
      end
      default: s = SAMPLE_BITS'($signed($urandom_range(0, 2)) - 1);
    endcase
    return s;
  endfunction

  // result side
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      tracker.match_peak('{level_o, peak_min_o, peak_max_o, last_of_run_o});
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned cc_tab[8];
    int unsigned cf_tab[8];
    int unsigned ms_tab[8];
    int unsigned cc, cf, ms;
    int          n_items;
    bit          eos;
    cc_tab          = '{1, 8, 0, 15, 3, 8, 2, 5};
    cf_tab          = '{1, 3, 0, 2, 5, 65535, 4, 2};
    ms_tab          = '{1, 4, 0, 3, 1023, 7, 5, 2};
    tracker         = new();
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sample_i        = '0;
    end_of_stream_i = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    tx_calm         = 1'b0;
    rx_calm         = 1'b0;
    hold_req        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: two channels, stream ends inside the first chunk
    send_sample(18'sd1000, 1'b0);
    send_sample(-18'sd2000, 1'b0);
    send_sample(18'sd300, 1'b0);
    send_sample(18'sd0, 1'b1);
    drain();

    configure(2, 2, 2);
    // full-scale frames clamp to +-1
    send_sample(18'sd131071, 1'b0);
    send_sample(18'sd131071, 1'b0);
    send_sample(-18'sd131072, 1'b0);
    send_sample(-18'sd131072, 1'b0);
    // just inside full scale, odd sums truncate toward zero
    send_sample(18'sd32768, 1'b0);
    send_sample(18'sd32767, 1'b0);
    send_sample(-18'sd32768, 1'b0);
    send_sample(-18'sd32767, 1'b0);
    // end of stream on the sample that completes a frame
    send_sample(-18'sd1, 1'b0);
    send_sample(18'sd0, 1'b0);
    send_sample(18'sd1, 1'b0);
    send_sample(18'sd0, 1'b1);
    // end of stream with nothing collected
    send_sample(18'sd5, 1'b1);
    // end of stream inside a frame drops that frame
    send_sample(18'sd100, 1'b0);
    send_sample(18'sd100, 1'b0);
    send_sample(18'sd7, 1'b1);
    // a closed chunk leaves a group tail for a lone end of stream
    send_sample(-18'sd5, 1'b0);
    send_sample(-18'sd4, 1'b0);
    send_sample(18'sd1, 1'b0);
    send_sample(18'sd1, 1'b0);
    send_sample(18'sd0, 1'b1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 8) begin
        cc = cc_tab[phase];
        cf = cf_tab[phase];
        ms = ms_tab[phase];
      end else begin
        cc = $urandom_range(0, 15);
        cf = $urandom_range(0, 9);
        ms = $urandom_range(0, 12);
      end
      configure(cc, cf, ms);
      n_items = (cf == 65535) ? 60 : 135;
      if (phase == 3) hold_req = 1'b1;
      for (int i = 0; i < n_items; i++) begin
        if (i % 40 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        eos = (i == n_items - 1) || ($urandom_range(0, 79) == 0);
        send_sample(pick_sample(), eos);
        // sender waits for every result to come back
        if (!eos && (i == 70 || $urandom_range(0, 99) == 0)) begin
          in_valid_i <= 1'b0;
          while (tracker.pending_peaks.size() != 0) @(posedge clk_i);
          @(negedge clk_i);
        end
      end
      drain();
    end

    if (tracker.errors == 0 && tracker.pending_peaks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
